>>> src/positional_array_list_assert.svh
`ifndef POSITIONAL_ARRAY_LIST_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define PAL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("positional_array_list: check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define PAL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("positional_array_list: check failed");

`endif

>>> src/pal_pkg.sv
package pal_pkg;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_READ   = 2'd2,
        KIND_SEARCH = 2'd3
    } t_kind;

    localparam logic       STATUS_DONE  = 1'b0;
    localparam logic       STATUS_ERROR = 1'b1;
    localparam logic [4:0] FOUND_NONE   = 5'b11111;

endpackage

>>> src/positional_array_list.sv
// Ordered list of signed 32-bit values, up to CAPACITY entries, kept in a single-port-style
// memory (one read and one write per cycle, registered read data) under a small sequencer.
// Each input beat is one operation and yields one result beat. A read fetches the addressed
// word. An insert moves the entries from its position up by one and writes the value (an
// append needs no move); a remove moves the entries above its position down by one;
// a search scans up from entry 0 to the first match or the last entry. A rejected operation
// or a search of an empty list goes straight to its result. Shifts and the search scan move
// one entry per cycle through the memory port. The input is ready only while the sequencer
// is idle. A finished result waits in the output register; if the previous result has not
// been taken yet, the sequencer holds it and stays busy until the output register frees up.
`include "positional_array_list_assert.svh"

module positional_array_list #(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,  // position[3:0], value[35:4], zero fill
    input  logic [1:0]  i_s_axis_tuser,  // kind[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,  // found_index[4:0], read_value[36:5],
                                         // entry_count[41:37], zero fill
    output logic        o_m_axis_tuser   // status[0]
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 4) ? CW : 4;
    localparam int XW = (CW > 5) ? CW : 5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_DRAIN,
        S_PUT,
        S_READ,
        S_SEARCH,
        S_DONE
    } t_state;

    t_state               r_state;
    pal_pkg::t_kind       r_kind;
    logic signed [31:0]   r_value;
    logic [AW-1:0]        r_pos;
    logic [AW-1:0]        r_rp;
    logic [AW-1:0]        r_wa;
    logic [AW-1:0]        r_cidx;
    logic                 r_pend;
    logic [CW-1:0]        r_cnt;
    logic                 r_res_status;
    logic [4:0]           r_res_found;
    logic signed [31:0]   r_res_readv;
    logic                 r_out_valid;
    logic                 r_out_status;
    logic [4:0]           r_out_found;
    logic signed [31:0]   r_out_readv;
    logic [4:0]           r_out_count;

    logic signed [31:0]   r_mem [CAPACITY];
    logic signed [31:0]   r_rdata;

    pal_pkg::t_kind       w_kind;
    logic [3:0]           w_pos;
    logic signed [31:0]   w_value;
    logic [PW-1:0]        w_pos_x;
    logic [PW-1:0]        w_cnt_x;
    logic [AW-1:0]        w_pos_idx;
    logic [CW-1:0]        w_cnt_dec;
    logic [AW-1:0]        w_last_idx;
    logic                 w_full;
    logic [XW-1:0]        w_cidx_x;
    logic [XW-1:0]        w_count_x;
    logic                 w_insert;
    logic                 w_in_err;

    logic                 w_we;
    logic [AW-1:0]        w_wa;
    logic signed [31:0]   w_wd;
    logic [AW-1:0]        w_ra;

    assign w_kind     = pal_pkg::t_kind'(i_s_axis_tuser);
    assign w_pos      = i_s_axis_tdata[3:0];
    assign w_value    = i_s_axis_tdata[35:4];
    assign w_pos_x    = PW'(w_pos);
    assign w_cnt_x    = PW'(r_cnt);
    assign w_pos_idx  = w_pos_x[AW-1:0];
    assign w_cnt_dec  = r_cnt - CW'(1);
    assign w_last_idx = w_cnt_dec[AW-1:0];
    assign w_full     = (r_cnt == CW'(CAPACITY));
    assign w_cidx_x   = XW'(r_cidx);
    assign w_count_x  = XW'(r_cnt);
    assign w_insert   = (r_kind == pal_pkg::KIND_INSERT);

    // An insert must fit and land at or below the count; remove and read need a live entry.
    assign w_in_err = (w_kind == pal_pkg::KIND_INSERT) ? (w_full || (w_pos_x > w_cnt_x)) :
                      (w_kind == pal_pkg::KIND_SEARCH) ? 1'b0 : (w_pos_x >= w_cnt_x);

    // Memory port control: during a shift, the word read last cycle lands one slot over.
    assign w_we = ((r_state == S_SHIFT) && r_pend) || (r_state == S_DRAIN) || (r_state == S_PUT);
    assign w_wa = (r_state == S_PUT) ? r_pos : r_wa;
    assign w_wd = (r_state == S_PUT) ? r_value : r_rdata;
    assign w_ra = (r_state == S_IDLE) ? w_pos_idx : r_rp;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rdata <= r_mem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            if (r_out_valid && i_m_axis_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_kind       <= w_kind;
                        r_value      <= w_value;
                        r_pos        <= w_pos_idx;
                        r_pend       <= 1'b0;
                        r_res_status <= w_in_err ? pal_pkg::STATUS_ERROR
                                                 : pal_pkg::STATUS_DONE;
                        r_res_found  <= (w_kind == pal_pkg::KIND_SEARCH) ? pal_pkg::FOUND_NONE
                                                                          : 5'b0;
                        r_res_readv  <= '0;
                        unique case (w_kind)
                            pal_pkg::KIND_INSERT: begin
                                if (w_in_err) begin
                                    r_state <= S_DONE;
                                end else if (w_pos_x == w_cnt_x) begin
                                    r_state <= S_PUT;
                                end else begin
                                    r_rp    <= w_last_idx;
                                    r_state <= S_SHIFT;
                                end
                            end
                            pal_pkg::KIND_REMOVE: begin
                                if (w_in_err) begin
                                    r_state <= S_DONE;
                                end else if ((w_pos_x + PW'(1)) == w_cnt_x) begin
                                    // Removing the last entry needs no shift.
                                    r_cnt   <= w_cnt_dec;
                                    r_state <= S_DONE;
                                end else begin
                                    r_rp    <= w_pos_idx + AW'(1);
                                    r_state <= S_SHIFT;
                                end
                            end
                            pal_pkg::KIND_READ: begin
                                if (w_in_err) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_READ;
                                end
                            end
                            pal_pkg::KIND_SEARCH: begin
                                if (r_cnt == '0) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_rp    <= '0;
                                    r_state <= S_SEARCH;
                                end
                            end
                        endcase
                    end
                end
                S_SHIFT: begin
                    // Insert walks down from the top entry, remove walks up.
                    r_pend <= 1'b1;
                    if (w_insert) begin
                        r_wa <= r_rp + AW'(1);
                        r_rp <= r_rp - AW'(1);
                        if (r_rp == r_pos) begin
                            r_state <= S_DRAIN;
                        end
                    end else begin
                        r_wa <= r_rp - AW'(1);
                        r_rp <= r_rp + AW'(1);
                        if (r_rp == w_last_idx) begin
                            r_state <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN: begin
                    if (w_insert) begin
                        r_state <= S_PUT;
                    end else begin
                        r_cnt   <= w_cnt_dec;
                        r_state <= S_DONE;
                    end
                end
                S_PUT: begin
                    r_cnt   <= r_cnt + CW'(1);
                    r_state <= S_DONE;
                end
                S_READ: begin
                    r_res_readv <= r_rdata;
                    r_state     <= S_DONE;
                end
                S_SEARCH: begin
                    // The word compared now was addressed in the previous cycle.
                    r_pend <= 1'b1;
                    r_cidx <= r_rp;
                    r_rp   <= r_rp + AW'(1);
                    if (r_pend) begin
                        if (r_rdata == r_value) begin
                            r_res_found <= w_cidx_x[4:0];
                            r_state     <= S_DONE;
                        end else if (r_cidx == w_last_idx) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_found  <= r_res_found;
                        r_out_readv  <= r_res_readv;
                        r_out_count  <= w_count_x[4:0];
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {6'b0, r_out_count, r_out_readv, r_out_found};

    // The count moves by at most one entry per cycle.
    `PAL_ASSERT_NEXT(a_busy_after_accept, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)
    `PAL_ASSERT_NOW(a_count_in_range, 1'b1, r_cnt <= CW'(CAPACITY))
    `PAL_ASSERT_NOW(a_count_steps_by_one, 1'b1, r_cnt - $past(r_cnt) + CW'(1) <= CW'(2))
    `PAL_ASSERT_NOW(a_no_write_when_idle, w_we, (r_state != S_IDLE) && (r_state != S_DONE))

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int LIST_DEPTH  = 16;
    localparam int IDLE_LIMIT  = 4000;
    localparam int RANDOM_OPS  = 1600;
    localparam int REPORT_MAX  = 10;

    typedef struct {
        pal_pkg::t_kind kind;
        logic [3:0]     position;
        logic [31:0]    value;
        bit             hold;     // wait for every pending result before this beat
    } t_list_op;

    typedef struct {
        logic        status;
        logic [4:0]  found;
        logic [31:0] read_value;
        logic [4:0]  entry_count;
    } t_list_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [39:0] s_tdata = '0;   // position[3:0], value[35:4], zero fill
    logic [1:0]  s_tuser = '0;   // kind[1:0]
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [47:0] m_tdata;        // found_index[4:0], read_value[36:5], entry_count[41:37]
    logic        m_tuser;        // status[0]

    t_list_op     pending_ops[$];
    t_list_result awaited_results[$];

    // Predicted list contents and length.
    logic [31:0] list_mem[LIST_DEPTH];
    int          list_len = 0;

    // Length of the list as seen while building stimulus.
    int          gen_len = 0;
    logic [31:0] value_pool[8];

    int          mismatches = 0;
    int          idle_cycles = 0;

    positional_array_list #(
        .CAPACITY(LIST_DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_list_result apply_list_op(t_list_op op);
        t_list_result r;
        int i;
        r.status      = pal_pkg::STATUS_DONE;
        r.found       = '0;
        r.read_value  = '0;
        case (op.kind)
            pal_pkg::KIND_INSERT: begin
                if (list_len >= LIST_DEPTH || op.position > list_len) begin
                    r.status = pal_pkg::STATUS_ERROR;
                end else begin
                    for (i = list_len; i > op.position; i--)
                        list_mem[i] = list_mem[i - 1];
                    list_mem[op.position] = op.value;
                    list_len++;
                end
            end
            pal_pkg::KIND_REMOVE: begin
                if (op.position >= list_len) begin
                    r.status = pal_pkg::STATUS_ERROR;
                end else begin
                    for (i = op.position; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i + 1];
                    list_len--;
                end
            end
            pal_pkg::KIND_READ: begin
                if (op.position >= list_len)
                    r.status = pal_pkg::STATUS_ERROR;
                else
                    r.read_value = list_mem[op.position];
            end
            default: begin
                r.found = pal_pkg::FOUND_NONE;
                for (i = list_len - 1; i >= 0; i--) begin
                    if (list_mem[i] == op.value)
                        r.found = i[4:0];
                end
            end
        endcase
        r.entry_count = list_len[4:0];
        return r;
    endfunction

    task automatic queue_op(pal_pkg::t_kind kind, int pos, logic [31:0] value, bit hold);
        t_list_op op;
        op.kind     = kind;
        op.position = pos[3:0];
        op.value    = value;
        op.hold     = hold;
        pending_ops.push_back(op);
        if (kind == pal_pkg::KIND_INSERT && gen_len < LIST_DEPTH && pos <= gen_len) begin
            gen_len++;
            value_pool[$urandom_range(0, 7)] = value;
        end else if (kind == pal_pkg::KIND_REMOVE && pos < gen_len) begin
            gen_len--;
        end
    endtask

    task automatic build_stimulus();
        int i;
        int r;
        int pos;
        bit filling;
        pal_pkg::t_kind kind;
        logic [31:0] value;

        value_pool = '{32'h0, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                       32'h5, 32'h1, 32'hdead_beef, 32'h0000_ffff};

        // Operations on an empty list, then a bad append position.
        queue_op(pal_pkg::KIND_READ, 0, 32'h0, 1'b0);
        queue_op(pal_pkg::KIND_REMOVE, 0, 32'h0, 1'b0);
        queue_op(pal_pkg::KIND_SEARCH, 0, 32'h0, 1'b0);
        queue_op(pal_pkg::KIND_INSERT, 1, 32'h1234_5678, 1'b0);
        queue_op(pal_pkg::KIND_INSERT, 0, 32'h7fff_ffff, 1'b0);
        queue_op(pal_pkg::KIND_INSERT, 0, 32'h8000_0000, 1'b0);
        queue_op(pal_pkg::KIND_INSERT, 2, 32'hffff_ffff, 1'b0);
        queue_op(pal_pkg::KIND_SEARCH, 0, 32'h8000_0000, 1'b0);
        queue_op(pal_pkg::KIND_READ, 2, 32'h0, 1'b0);
        queue_op(pal_pkg::KIND_READ, 3, 32'h0, 1'b0);
        // Fill to capacity with some duplicates so a search must pick the first match.
        for (i = 3; i < LIST_DEPTH; i++)
            queue_op(pal_pkg::KIND_INSERT, (i % 2 == 1) ? i : 1,
                     (i % 3 == 0) ? 32'h5 : $urandom, 1'b0);
        queue_op(pal_pkg::KIND_INSERT, 15, 32'h0, 1'b0);
        queue_op(pal_pkg::KIND_SEARCH, 0, 32'h5, 1'b0);
        queue_op(pal_pkg::KIND_READ, 15, 32'h0, 1'b0);
        queue_op(pal_pkg::KIND_REMOVE, 15, 32'h0, 1'b0);
        queue_op(pal_pkg::KIND_REMOVE, 0, 32'h0, 1'b0);
        queue_op(pal_pkg::KIND_SEARCH, 7, 32'h0bad_cafe, 1'b0);

        // Random part drifts between filling and draining so the length sweeps its range.
        filling = 1'b0;
        for (i = 0; i < RANDOM_OPS; i++) begin
            if (gen_len >= LIST_DEPTH)
                filling = 1'b0;
            else if (gen_len == 0)
                filling = 1'b1;
            else if ($urandom_range(0, 49) == 0)
                filling = ~filling;

            r = $urandom_range(0, 99);
            if (filling) begin
                if (r < 50)
                    kind = pal_pkg::KIND_INSERT;
                else if (r < 65)
                    kind = pal_pkg::KIND_REMOVE;
                else if (r < 85)
                    kind = pal_pkg::KIND_READ;
                else
                    kind = pal_pkg::KIND_SEARCH;
            end else begin
                if (r < 15)
                    kind = pal_pkg::KIND_INSERT;
                else if (r < 60)
                    kind = pal_pkg::KIND_REMOVE;
                else if (r < 80)
                    kind = pal_pkg::KIND_READ;
                else
                    kind = pal_pkg::KIND_SEARCH;
            end

            if ($urandom_range(0, 99) < 85) begin
                if (kind == pal_pkg::KIND_INSERT)
                    pos = $urandom_range(0, (gen_len > 15) ? 15 : gen_len);
                else if (gen_len > 0)
                    pos = $urandom_range(0, gen_len - 1);
                else
                    pos = 0;
            end else begin
                pos = $urandom_range(0, 15);
            end

            if ($urandom_range(0, 99) < ((kind == pal_pkg::KIND_SEARCH) ? 60 : 35))
                value = value_pool[$urandom_range(0, 7)];
            else
                value = $urandom;

            queue_op(kind, pos, value, (i % 400) == 0);
        end
    endtask

    // Driver: bursts of beats separated by random gaps.
    int       burst_left = 1;
    int       gap_left = 0;
    t_list_op cur_op;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                awaited_results.push_back(apply_list_op(cur_op));
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_ops.size() == 0 ||
                             (pending_ops[0].hold && awaited_results.size() != 0)) begin
                    s_valid <= 1'b0;
                end else begin
                    cur_op = pending_ops.pop_front();
                    s_tdata <= {4'b0, cur_op.value, cur_op.position};
                    s_tuser <= cur_op.kind;
                    s_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 30);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // Monitor: the ready pattern moves among four modes, picked at random.
    int stall_cnt = 0;
    int stall_mode = 0;
    t_list_result want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected result beat: tdata=%h tuser=%b", m_tdata, m_tuser);
                end else begin
                    want = awaited_results.pop_front();
                    if (m_tuser !== want.status || m_tdata[4:0] !== want.found ||
                        m_tdata[36:5] !== want.read_value ||
                        m_tdata[41:37] !== want.entry_count ||
                        m_tdata[47:42] !== 6'b0) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("result mismatch: expected status=%b found=%0d read=%0d",
                                     want.status, $signed(want.found),
                                     $signed(want.read_value),
                                     " count=%0d, got status=%b found=%0d read=%0d",
                                     want.entry_count,
                                     m_tuser, $signed(m_tdata[4:0]),
                                     $signed(m_tdata[36:5]),
                                     " count=%0d fill=%h",
                                     m_tdata[41:37], m_tdata[47:42]);
                    end
                end
            end
            stall_cnt++;
            if (stall_cnt % 64 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= (stall_cnt % 4 == 0);
                default: m_ready <= (stall_cnt % 13 < 3);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        build_stimulus();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (pending_ops.size() != 0 || s_valid || awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
